/* design/dnsp_pkg.sv */
`default_nettype none

package dnsp_pkg;

    // Upper bound on length bytes read for one name.
    localparam int unsigned MAX_LABELS = 128;

    // Largest plain label length; larger values are pointers or errors.
    localparam logic [7:0] LABEL_MAX_LEN = 8'd63;

    // Response header checks.
    localparam logic [15:0] FLAG_RESPONSE = 16'h8000;
    localparam logic [15:0] FLAG_RCODE = 16'h000F;
    localparam logic [7:0] PTR_MASK = 8'hC0;

    // Resource record values for an IPv4 address record.
    localparam logic [15:0] RR_TYPE_A = 16'd1;
    localparam logic [15:0] RR_CLASS_IN = 16'd1;
    localparam logic [15:0] RR_A_LEN = 16'd4;

    // Configuration register indexes.
    localparam logic [7:0] REG_QUERY_ACTIVE = 8'd0;
    localparam logic [7:0] REG_EXPECTED_ID = 8'd1;

    // Result status codes.
    localparam logic [1:0] ST_IGNORED = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_FOUND = 2'd2;

    // Width of tdata on the result side: 66 bits of fields padded to bytes.
    localparam int unsigned RES_BITS = 2 + 32 + 32;
    localparam int unsigned RES_TDATA_W = ((RES_BITS + 7) / 8) * 8;

    // Parser phases.
    typedef enum logic [6:0] {
        PH_HEADER = 7'b0000001,
        PH_NAME   = 7'b0000010,
        PH_PTR    = 7'b0000100,
        PH_QFIXED = 7'b0001000,
        PH_AFIXED = 7'b0010000,
        PH_RDATA  = 7'b0100000,
        PH_DONE   = 7'b1000000
    } phase_t;

    // One result of a datagram.
    typedef struct packed {
        logic [31:0] ttl;
        logic [31:0] address;
        logic [1:0]  status;
    } result_t;

endpackage

`default_nettype wire

/* design/dnsp_parser.sv */
`default_nettype none

module dnsp_parser (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              byte_accept,
    input  wire logic [7:0]        data_byte,
    input  wire logic              last_byte,
    input  wire logic              query_active,
    input  wire logic [15:0]       expected_id,
    output logic                   res_valid,
    output dnsp_pkg::result_t      res_data
);
    import dnsp_pkg::*;

    // Parse state registers.
    phase_t      phase_reg, phase_next;
    logic [3:0]  byte_pos_reg, byte_pos_next;
    logic [31:0] shift_reg, shift_next;
    logic        flags_bad_reg, flags_bad_next;
    logic [15:0] q_left_reg, q_left_next;
    logic [15:0] a_left_reg, a_left_next;
    logic [5:0]  label_left_reg, label_left_next;
    logic [7:0]  labels_seen_reg, labels_seen_next;
    logic        type_ok_reg, type_ok_next;
    logic        class_ok_reg, class_ok_next;
    logic [31:0] ttl_reg, ttl_next;
    logic [15:0] data_left_reg, data_left_next;
    logic [31:0] addr_reg, addr_next;
    logic [1:0]  outcome_reg, outcome_next;

    logic        go_next_item;
    logic        go_name_done;
    logic [1:0]  status;

    // Next state for one byte.
    always_comb begin
        phase_next       = phase_reg;
        byte_pos_next    = byte_pos_reg;
        shift_next       = {shift_reg[23:0], data_byte};
        flags_bad_next   = flags_bad_reg;
        q_left_next      = q_left_reg;
        a_left_next      = a_left_reg;
        label_left_next  = label_left_reg;
        labels_seen_next = labels_seen_reg;
        type_ok_next     = type_ok_reg;
        class_ok_next    = class_ok_reg;
        ttl_next         = ttl_reg;
        data_left_next   = data_left_reg;
        addr_next        = addr_reg;
        outcome_next     = outcome_reg;
        go_next_item     = 1'b0;
        go_name_done     = 1'b0;

        unique case (phase_reg)
            PH_HEADER: begin
                byte_pos_next = byte_pos_reg + 4'd1;
                if (byte_pos_reg == 4'd1 && shift_next[15:0] != expected_id) begin
                    phase_next   = PH_DONE;
                    outcome_next = ST_IGNORED;
                end else if (byte_pos_reg == 4'd11) begin
                    if (flags_bad_reg) begin
                        phase_next   = PH_DONE;
                        outcome_next = ST_FAIL;
                    end else begin
                        go_next_item = 1'b1;
                    end
                end
                if (byte_pos_reg == 4'd3) begin
                    flags_bad_next = ((shift_next[15:0] & FLAG_RESPONSE) == 16'd0)
                                  || ((shift_next[15:0] & FLAG_RCODE) != 16'd0);
                end
                if (byte_pos_reg == 4'd5) q_left_next = shift_next[15:0];
                if (byte_pos_reg == 4'd7) a_left_next = shift_next[15:0];
            end
            PH_NAME: begin
                // Skip label bytes, then interpret the next length byte.
                if (label_left_reg != 6'd0) begin
                    label_left_next = label_left_reg - 6'd1;
                end else if (labels_seen_reg >= 8'(MAX_LABELS)) begin
                    phase_next   = PH_DONE;
                    outcome_next = ST_FAIL;
                end else begin
                    labels_seen_next = labels_seen_reg + 8'd1;
                    if (data_byte == 8'd0) begin
                        go_name_done = 1'b1;
                    end else if ((data_byte & PTR_MASK) == PTR_MASK) begin
                        phase_next = PH_PTR;
                    end else if (data_byte > LABEL_MAX_LEN) begin
                        phase_next   = PH_DONE;
                        outcome_next = ST_FAIL;
                    end else begin
                        label_left_next = data_byte[5:0];
                    end
                end
            end
            PH_PTR: begin
                go_name_done = 1'b1;
            end
            PH_QFIXED: begin
                byte_pos_next = byte_pos_reg + 4'd1;
                if (byte_pos_reg == 4'd3) begin
                    q_left_next  = q_left_reg - 16'd1;
                    go_next_item = 1'b1;
                end
            end
            PH_AFIXED: begin
                byte_pos_next = byte_pos_reg + 4'd1;
                if (byte_pos_reg == 4'd1) type_ok_next = (shift_next[15:0] == RR_TYPE_A);
                if (byte_pos_reg == 4'd3) class_ok_next = (shift_next[15:0] == RR_CLASS_IN);
                if (byte_pos_reg == 4'd7) ttl_next = shift_next;
                if (byte_pos_reg == 4'd9) begin
                    data_left_next = shift_next[15:0];
                    outcome_next   = (type_ok_reg && class_ok_reg
                                      && shift_next[15:0] == RR_A_LEN) ? ST_FOUND
                                                                       : ST_IGNORED;
                    if (shift_next[15:0] == 16'd0) begin
                        a_left_next  = a_left_reg - 16'd1;
                        go_next_item = 1'b1;
                    end else begin
                        phase_next = PH_RDATA;
                    end
                end
            end
            PH_RDATA: begin
                data_left_next = data_left_reg - 16'd1;
                if (data_left_reg == 16'd1) begin
                    if (outcome_reg == ST_FOUND) begin
                        addr_next    = shift_next;
                        phase_next   = PH_DONE;
                        outcome_next = ST_FOUND;
                    end else begin
                        a_left_next  = a_left_reg - 16'd1;
                        go_next_item = 1'b1;
                    end
                end
            end
            PH_DONE: begin
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase

        // End of a name: the fixed part follows.
        if (go_name_done) begin
            byte_pos_next = 4'd0;
            phase_next    = (q_left_reg != 16'd0) ? PH_QFIXED : PH_AFIXED;
        end

        // Start the next name, or stop when none is left.
        if (go_next_item) begin
            if (q_left_next != 16'd0 || a_left_next != 16'd0) begin
                phase_next       = PH_NAME;
                label_left_next  = 6'd0;
                labels_seen_next = 8'd0;
            end else begin
                phase_next   = PH_DONE;
                outcome_next = ST_FAIL;
            end
        end
    end

    // Status seen after the last byte has been taken.
    always_comb begin
        if (phase_next == PH_DONE) begin
            status = outcome_next;
        end else if (phase_next == PH_HEADER) begin
            status = ST_IGNORED;
        end else begin
            status = ST_FAIL;
        end
        if (!query_active) begin
            status = ST_IGNORED;
        end
    end

    assign res_valid        = byte_accept && last_byte;
    assign res_data.status  = status;
    assign res_data.address = (status == ST_FOUND) ? addr_next : 32'd0;
    assign res_data.ttl     = (status == ST_FOUND) ? ttl_next : 32'd0;

    // State update; the last byte of a datagram returns everything to reset.
    always_ff @(posedge aclk) begin
        if (!aresetn || (byte_accept && last_byte)) begin
            phase_reg       <= PH_HEADER;
            byte_pos_reg    <= 4'd0;
            shift_reg       <= 32'd0;
            flags_bad_reg   <= 1'b0;
            q_left_reg      <= 16'd0;
            a_left_reg      <= 16'd0;
            label_left_reg  <= 6'd0;
            labels_seen_reg <= 8'd0;
            type_ok_reg     <= 1'b0;
            class_ok_reg    <= 1'b0;
            ttl_reg         <= 32'd0;
            data_left_reg   <= 16'd0;
            addr_reg        <= 32'd0;
            outcome_reg     <= ST_IGNORED;
        end else if (byte_accept) begin
            phase_reg       <= phase_next;
            byte_pos_reg    <= byte_pos_next;
            shift_reg       <= shift_next;
            flags_bad_reg   <= flags_bad_next;
            q_left_reg      <= q_left_next;
            a_left_reg      <= a_left_next;
            label_left_reg  <= label_left_next;
            labels_seen_reg <= labels_seen_next;
            type_ok_reg     <= type_ok_next;
            class_ok_reg    <= class_ok_next;
            ttl_reg         <= ttl_next;
            data_left_reg   <= data_left_next;
            addr_reg        <= addr_next;
            outcome_reg     <= outcome_next;
        end
    end

`ifndef ASSERT_OFF
    // Pending label bytes exist only while a name is being skipped.
    a_label_in_name: assert property (@(posedge aclk) disable iff (!aresetn)
        label_left_reg != 6'd0 |-> phase_reg == PH_NAME)
        else $error("label byte count outside name phase");

    // A finished datagram leaves the parser at the start of a header.
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_accept && last_byte |=> phase_reg == PH_HEADER && byte_pos_reg == 4'd0)
        else $error("parse state not cleared after last byte");

    // Address and TTL are reported only with a found record.
    a_zero_unless_found: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res_data.status != ST_FOUND
        |-> res_data.address == 32'd0 && res_data.ttl == 32'd0)
        else $error("address or TTL nonzero without a found record");

    // The label counter never runs past its limit.
    a_label_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        labels_seen_reg <= 8'(MAX_LABELS))
        else $error("label count above limit");
`endif

endmodule

`default_nettype wire

/* design/dnsp_out_buf.sv */
`default_nettype none

module dnsp_out_buf (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push_valid,
    input  wire dnsp_pkg::result_t push_data,
    output logic                   push_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output dnsp_pkg::result_t      m_data
);
    import dnsp_pkg::*;

    // Output register plus a skid entry behind it.
    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_data_reg, main_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;
    logic    push;

    assign push_ready = !skid_valid_reg;
    assign pop        = main_valid_reg && m_ready;
    assign push       = push_valid && push_ready;
    assign m_valid    = main_valid_reg;
    assign m_data     = main_data_reg;

    // Move results forward; the skid entry refills the output register first.
    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = push;
                main_data_next  = push_data;
            end
        end else if (push) begin
            if (!main_valid_reg) begin
                main_valid_next = 1'b1;
                main_data_next  = push_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

`ifndef ASSERT_OFF
    // The skid entry is only used behind a full output register.
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry holds data with output register empty");

    // The skid entry fills only when the output register is stalled.
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(main_valid_reg && !m_ready && push_valid))
        else $error("skid entry filled without a stall");

    // A stalled skid entry keeps its result.
    a_skid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !m_ready |=> skid_valid_reg && $stable(skid_data_reg))
        else $error("skid entry changed while stalled");
`endif

endmodule

`default_nettype wire

/* design/dns_a_record_response_parser.sv */
`default_nettype none

// DNS response parser for IPv4 address records. Payload bytes enter on the
// s_ stream, one byte per transaction, with s_tlast on the final byte of
// the datagram; one result leaves on the m_ stream for every datagram. It is
// presented from the cycle after its last byte is taken, or later when older
// results still wait on the m_ side. The parser is a per-byte state
// update between its state registers and a two-entry output buffer, so it
// takes one byte every cycle; s_tready drops only when two results are
// waiting on the m_ side. Status 0 means ignored (no query active, short
// header or identifier mismatch), 1 means malformed or no address record,
// 2 means found with the address and TTL of the first IN A record.
// Program query_active and expected_id through the cfg_ port between
// datagrams; query_active is sampled on the last byte, expected_id on the
// second header byte. There is no startup clearing pass.
module dns_a_record_response_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Payload stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // last_byte
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [dnsp_pkg::RES_TDATA_W-1:0] m_tdata,
    // m_tdata: [1:0] status, [33:2] address, [65:34] ttl, rest zero
    // Configuration writes.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import dnsp_pkg::*;

    logic        query_active_reg;
    logic [15:0] expected_id_reg;
    logic        byte_accept;
    logic        res_valid;
    result_t     res_data;
    result_t     out_data;

    // Configuration registers; writes to unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_active_reg <= 1'b0;
            expected_id_reg  <= 16'd0;
        end else if (cfg_valid) begin
            if (cfg_index == REG_QUERY_ACTIVE) query_active_reg <= cfg_data[0];
            if (cfg_index == REG_EXPECTED_ID) expected_id_reg <= cfg_data;
        end
    end

    assign byte_accept = s_tvalid && s_tready;

    dnsp_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_accept  (byte_accept),
        .data_byte    (s_tdata),
        .last_byte    (s_tlast),
        .query_active (query_active_reg),
        .expected_id  (expected_id_reg),
        .res_valid    (res_valid),
        .res_data     (res_data)
    );

    dnsp_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (res_valid),
        .push_data  (res_data),
        .push_ready (s_tready),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_data     (out_data)
    );

    // Pack the result with status in the lowest bits.
    assign m_tdata = RES_TDATA_W'({out_data.ttl, out_data.address,
                                   out_data.status});

endmodule

`default_nettype wire
